// ----- src/pnc_pkg.sv -----
`default_nettype none

package pnc_pkg;

  // Sizes of the two palettes
  localparam int unsigned SOURCE_COLORS  = 256;
  localparam int unsigned REDUCED_COLORS = 16;

  localparam int unsigned SRC_IDX_W = (SOURCE_COLORS > 1) ? $clog2(SOURCE_COLORS) : 1;
  localparam int unsigned IDX_W     = (REDUCED_COLORS > 1) ? $clog2(REDUCED_COLORS) : 1;
  localparam int unsigned CNT_W     = $clog2(REDUCED_COLORS + 1);

  // Squared RGB distance: 3 * 255^2 fits in 18 bits
  localparam int unsigned DIST_W = 18;

  // Register reset values
  localparam logic [12:0] WIDTH_RST  = 13'd1024;
  localparam logic [12:0] HEIGHT_RST = 13'd768;
  localparam logic [17:0] THR_RST    = 18'd1600;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_WIDTH     = 2'd0,
    CFG_HEIGHT    = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_idx_e;

  // Request kinds
  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_PIXEL = 1'b1
  } req_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Token handed from cell to cell down the chain
  typedef struct packed {
    logic              valid;
    req_e              kind;
    rgb_t              probe;
    logic              has_best;
    logic [DIST_W-1:0] best_d;
    logic [IDX_W-1:0]  best_idx;
    rgb_t              best_color;
    logic              present;
  } token_t;

  // Broadcast write of a new reduced palette entry
  typedef struct packed {
    logic en;
    rgb_t color;
  } pal_wr_t;

  function automatic logic [DIST_W-1:0] sq_dist(rgb_t a, rgb_t b);
    logic [7:0]  dr;
    logic [7:0]  dg;
    logic [7:0]  db;
    logic [15:0] sr;
    logic [15:0] sg;
    logic [15:0] sb;
    dr = (a.r > b.r) ? a.r - b.r : b.r - a.r;
    dg = (a.g > b.g) ? a.g - b.g : b.g - a.g;
    db = (a.b > b.b) ? a.b - b.b : b.b - a.b;
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    return DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
  endfunction

  // First row of a frame: height - 1, saturated to the 12-bit counter
  function automatic logic [11:0] start_row(logic [12:0] height);
    logic [12:0] hm1;
    hm1 = height - 13'd1;
    if (height == 13'd0) begin
      return 12'd0;
    end else if (hm1[12]) begin
      return 12'hFFF;
    end else begin
      return hm1[11:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- src/pnc_cell.sv -----
`default_nettype none

// One reduced palette entry plus its distance unit. Each cycle it takes the
// token from its left neighbor, folds in its own entry and passes it right.
module pnc_cell
  import pnc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [IDX_W-1:0]  idx_i,
  input  wire logic [CNT_W-1:0]  count_i,
  input  wire logic [DIST_W-1:0] threshold_i,
  input  wire pal_wr_t           wr_i,
  input  wire token_t            tok_i,
  output token_t                 tok_o
);

  rgb_t              entry_q;
  token_t            tok_d;
  token_t            tok_q;
  logic [DIST_W-1:0] cand_d;
  logic              used;
  logic              take;

  assign used   = CNT_W'(idx_i) < count_i;
  assign cand_d = sq_dist(tok_i.probe, entry_q);
  // first cell always wins, later ones only on a strictly smaller distance
  assign take = !tok_i.has_best || (cand_d < tok_i.best_d);

  // Fold this entry into the token
  always_comb begin
    tok_d = tok_i;
    case (tok_i.kind)
      REQ_PIXEL: begin
        if (take) begin
          tok_d.has_best   = 1'b1;
          tok_d.best_d     = cand_d;
          tok_d.best_idx   = idx_i;
          tok_d.best_color = entry_q;
        end
      end
      REQ_LOAD: begin
        tok_d.present = tok_i.present | (used & (cand_d < threshold_i));
      end
      default: begin
        tok_d = tok_i;
      end
    endcase
  end

  // Entry storage: black after reset, written when this is the next free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (wr_i.en && (CNT_W'(idx_i) == count_i)) begin
      entry_q <= wr_i.color;
    end
  end

  // Token stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ----- src/palette_reduce_and_nearest_color_map.sv -----
`default_nettype none

// Channel   | Signals                              | Direction
// ----------+--------------------------------------+-----------
// in        | in_valid_i / in_stall_o, item fields | request in
// out       | out_valid_o / out_stall_i, results   | result out
// cfg       | cfg_valid_i / cfg_ready_o, idx, data | register write
//
// One request at a time: a palette load passes the launch register, the
// 16-cell distance chain (one cell per cycle) and the pending register before
// the output register; a pixel first reads the source palette. The next
// request is taken once the result has moved into the output register.
// A result waiting in the output register does not block the next request.
// Reset clears the reduced palette to black and restarts the counters; the
// source palette keeps whatever it holds. Configuration is always ready.
module palette_reduce_and_nearest_color_map
  import pnc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // requests
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  entry_index_i,
  input  wire logic [7:0]  entry_red_i,
  input  wire logic [7:0]  entry_green_i,
  input  wire logic [7:0]  entry_blue_i,
  input  wire logic [7:0]  pixel_index_i,
  // results
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic             entry_added_o,
  output logic [4:0]       reduced_size_o,
  output logic [3:0]       color_index_o,
  output logic [7:0]       out_red_o,
  output logic [7:0]       out_green_o,
  output logic [7:0]       out_blue_o,
  output logic [11:0]      out_column_o,
  output logic [11:0]      out_row_o,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [17:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_RUN  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  typedef struct packed {
    req_e        kind;
    logic        added;
    logic [4:0]  size;
    logic [3:0]  idx;
    rgb_t        color;
    logic [11:0] column;
    logic [11:0] row;
  } result_t;

  state_e            state_q, state_d;
  logic [12:0]       width_q;
  logic [12:0]       height_q;
  logic [17:0]       thr_q;
  logic [CNT_W-1:0]  count_q;
  logic [11:0]       col_q;
  logic [11:0]       row_q;
  rgb_t              src_mem [SOURCE_COLORS];
  rgb_t              rd_q;
  logic              oor_q;
  token_t            launch_q;
  token_t            chain [REDUCED_COLORS+1];
  token_t            tail;
  pal_wr_t           pal_wr;
  result_t           res_d;
  result_t           pend_q;
  result_t           out_q;
  logic              out_valid_q;
  logic              in_acc;
  logic              cfg_acc;
  logic              arrive;
  logic              add;
  logic              col_wrap;
  logic              load_ok;
  logic              pix_ok;
  logic              out_free;

  assign in_stall_o  = !(state_q == S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign tail        = chain[REDUCED_COLORS];
  assign arrive      = tail.valid && (state_q == S_RUN);
  assign load_ok     = {1'b0, entry_index_i} < 9'(SOURCE_COLORS);
  assign pix_ok      = {1'b0, pixel_index_i} < 9'(SOURCE_COLORS);
  assign out_free    = !out_valid_q || !out_stall_i;

  // Control
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (req_type_i == REQ_PIXEL) ? S_READ : S_RUN;
        end
      end
      S_READ: state_d = S_RUN;
      S_RUN: begin
        if (tail.valid) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Source palette
  always_ff @(posedge clk_i) begin
    if (in_acc && (req_type_i == REQ_LOAD) && load_ok) begin
      src_mem[entry_index_i[SRC_IDX_W-1:0]] <= '{r: entry_red_i, g: entry_green_i,
                                                 b: entry_blue_i};
    end
    if (in_acc) begin
      rd_q  <= src_mem[pixel_index_i[SRC_IDX_W-1:0]];
      oor_q <= !pix_ok;
    end
  end

  // Token launch into the first cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= '0;
    end else begin
      launch_q.valid      <= (in_acc && (req_type_i == REQ_LOAD)) || (state_q == S_READ);
      launch_q.has_best   <= 1'b0;
      launch_q.best_d     <= '0;
      launch_q.best_idx   <= '0;
      launch_q.best_color <= '0;
      launch_q.present    <= 1'b0;
      if (state_q == S_READ) begin
        launch_q.kind  <= REQ_PIXEL;
        launch_q.probe <= oor_q ? '0 : rd_q;
      end else begin
        launch_q.kind  <= REQ_LOAD;
        launch_q.probe <= '{r: entry_red_i, g: entry_green_i, b: entry_blue_i};
      end
    end
  end

  // Cell chain
  assign chain[0] = launch_q;

  for (genvar k = 0; k < REDUCED_COLORS; k++) begin : g_cell
    pnc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (IDX_W'(k)),
      .count_i     (count_q),
      .threshold_i (thr_q),
      .wr_i        (pal_wr),
      .tok_i       (chain[k]),
      .tok_o       (chain[k+1])
    );
  end

  // Add decision at the end of the chain
  assign add          = arrive && (tail.kind == REQ_LOAD) &&
                        (count_q < CNT_W'(REDUCED_COLORS)) && !tail.present;
  assign pal_wr.en    = add;
  assign pal_wr.color = tail.probe;

  assign col_wrap = ({1'b0, col_q} + 13'd1 >= width_q) || (col_q == 12'hFFF);

  // Result assembly
  always_comb begin
    res_d = '0;
    res_d.kind = tail.kind;
    case (tail.kind)
      REQ_LOAD: begin
        res_d.added = add;
        res_d.size  = 5'(count_q + CNT_W'(add));
      end
      REQ_PIXEL: begin
        res_d.size   = 5'(count_q);
        res_d.idx    = 4'(tail.best_idx);
        res_d.color  = tail.best_color;
        res_d.column = col_q;
        res_d.row    = row_q;
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (arrive) begin
      pend_q <= res_d;
    end
  end

  // Registers, reduced count and raster counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      thr_q    <= THR_RST;
      count_q  <= '0;
      col_q    <= '0;
      row_q    <= start_row(HEIGHT_RST);
    end else begin
      if (add) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (arrive && (tail.kind == REQ_PIXEL)) begin
        if (col_wrap) begin
          col_q <= '0;
          row_q <= (row_q == 12'd0) ? start_row(height_q) : row_q - 12'd1;
        end else begin
          col_q <= col_q + 12'd1;
        end
      end
      if (cfg_acc) begin
        case (cfg_index_i)
          CFG_WIDTH:     width_q <= cfg_data_i[12:0];
          CFG_HEIGHT: begin
            height_q <= cfg_data_i[12:0];
            row_q    <= start_row(cfg_data_i[12:0]);
          end
          CFG_THRESHOLD: thr_q <= cfg_data_i;
          default:       ;
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && out_free) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_q.kind;
  assign entry_added_o  = out_q.added;
  assign reduced_size_o = out_q.size;
  assign color_index_o  = out_q.idx;
  assign out_red_o      = out_q.color.r;
  assign out_green_o    = out_q.color.g;
  assign out_blue_o     = out_q.color.b;
  assign out_column_o   = out_q.column;
  assign out_row_o      = out_q.row;

  // Checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_tail_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> (state_q == S_RUN))
    else $error("token left the chain outside of RUN");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(REDUCED_COLORS))
    else $error("reduced palette count overflow");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("second request taken while one is in flight");

endmodule

`default_nettype wire

// ----- test/tb_palette_reduce_and_nearest_color_map.sv -----
module tb_palette_reduce_and_nearest_color_map;
  import pnc_pkg::*;

  localparam int STUCK_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 25;
  localparam int IDLE_PCT      = 25;

  // Register write selection for a phase
  localparam logic [2:0] WR_WIDTH     = 3'b001;
  localparam logic [2:0] WR_HEIGHT    = 3'b010;
  localparam logic [2:0] WR_THRESHOLD = 3'b100;
  localparam logic [2:0] WR_ALL       = 3'b111;

  typedef struct packed {
    req_e       kind;
    logic [7:0] slot;
    rgb_t       color;
    logic [7:0] pix;
  } map_req_t;

  typedef struct packed {
    logic        kind;
    logic        added;
    logic [4:0]  size;
    logic [3:0]  cidx;
    rgb_t        color;
    logic [11:0] col;
    logic [11:0] row;
  } map_result_t;

  typedef struct packed {
    map_req_t    rq;
    logic        known;
    map_result_t golden;
  } dir_row_t;

  // DUT connections
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic        req_type_i    = 1'b0;
  logic [7:0]  entry_index_i = 8'd0;
  logic [7:0]  entry_red_i   = 8'd0;
  logic [7:0]  entry_green_i = 8'd0;
  logic [7:0]  entry_blue_i  = 8'd0;
  logic [7:0]  pixel_index_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic        result_kind_o;
  logic        entry_added_o;
  logic [4:0]  reduced_size_o;
  logic [3:0]  color_index_o;
  logic [7:0]  out_red_o;
  logic [7:0]  out_green_o;
  logic [7:0]  out_blue_o;
  logic [11:0] out_column_o;
  logic [11:0] out_row_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = CFG_WIDTH;
  logic [17:0] cfg_data_i    = 18'd0;

  // Predictor state
  rgb_t        src_pal     [SOURCE_COLORS];
  bit          src_written [SOURCE_COLORS];
  rgb_t        red_pal     [REDUCED_COLORS];
  logic [4:0]  red_count   = 5'd0;
  logic [11:0] col_cnt     = 12'd0;
  logic [11:0] row_cnt     = 12'd767;
  logic [12:0] width_reg   = WIDTH_RST;
  logic [12:0] height_reg  = HEIGHT_RST;
  logic [17:0] thr_reg     = THR_RST;

  map_result_t pending_results [$];
  dir_row_t    dir_rows [$];
  int          mismatch_count = 0;
  int          stuck_cycles   = 0;
  bit          quiet_mode     = 1'b0;

  palette_reduce_and_nearest_color_map DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .entry_index_i  (entry_index_i),
    .entry_red_i    (entry_red_i),
    .entry_green_i  (entry_green_i),
    .entry_blue_i   (entry_blue_i),
    .pixel_index_i  (pixel_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .entry_added_o  (entry_added_o),
    .reduced_size_o (reduced_size_o),
    .color_index_o  (color_index_o),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .out_column_o   (out_column_o),
    .out_row_o      (out_row_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic int color_dist(rgb_t a, rgb_t b);
    int dr, dg, db;
    dr = int'(a.r) - int'(b.r);
    dg = int'(a.g) - int'(b.g);
    db = int'(a.b) - int'(b.b);
    return dr * dr + dg * dg + db * db;
  endfunction

  // Top row of a frame, saturated to the 12-bit row counter
  function automatic logic [11:0] first_row(logic [12:0] h);
    if (h == 13'd0) return 12'd0;
    if (int'(h) - 1 > 4095) return 12'hFFF;
    return 12'(int'(h) - 1);
  endfunction

  function automatic logic [7:0] clamp_channel(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  function automatic map_req_t load_req(int slot, int r, int g, int b);
    map_req_t rq;
    rq = '0;
    rq.kind  = REQ_LOAD;
    rq.slot  = 8'(slot);
    rq.color = {8'(r), 8'(g), 8'(b)};
    return rq;
  endfunction

  function automatic map_req_t pixel_req(int pix);
    map_req_t rq;
    rq = '0;
    rq.kind = REQ_PIXEL;
    rq.pix  = 8'(pix);
    return rq;
  endfunction

  function automatic map_result_t golden_load(int added, int size);
    map_result_t res;
    res = '0;
    res.kind  = REQ_LOAD;
    res.added = 1'(added);
    res.size  = 5'(size);
    return res;
  endfunction

  function automatic map_result_t golden_pixel(int size, int cidx, int r, int g, int b,
                                               int col, int row);
    map_result_t res;
    res = '0;
    res.kind  = REQ_PIXEL;
    res.size  = 5'(size);
    res.cidx  = 4'(cidx);
    res.color = {8'(r), 8'(g), 8'(b)};
    res.col   = 12'(col);
    res.row   = 12'(row);
    return res;
  endfunction

  // Pixels only read source slots that were loaded before
  function automatic logic [7:0] pick_written_slot();
    int s;
    s = $urandom_range(SOURCE_COLORS - 1);
    for (int n = 0; n < SOURCE_COLORS; n++) begin
      if (src_written[(s + n) % SOURCE_COLORS]) return 8'((s + n) % SOURCE_COLORS);
    end
    return 8'd0;
  endfunction

  // Random request; unused fields carry noise
  function automatic map_req_t random_request(int load_pct);
    map_req_t rq;
    rgb_t     base;
    rq.kind  = REQ_LOAD;
    rq.slot  = 8'($urandom);
    rq.color = 24'($urandom);
    rq.pix   = 8'($urandom);
    if ($urandom_range(99) < load_pct) begin
      case ($urandom_range(2))
        0: ;
        1: begin
          // close to a kept color, around the threshold
          base = red_pal[$urandom_range(REDUCED_COLORS - 1)];
          rq.color.r = clamp_channel(int'(base.r) + int'($urandom_range(80)) - 40);
          rq.color.g = clamp_channel(int'(base.g) + int'($urandom_range(80)) - 40);
          rq.color.b = clamp_channel(int'(base.b) + int'($urandom_range(80)) - 40);
        end
        default: begin
          rq.color.r = $urandom_range(1) ? 8'd255 : 8'd0;
          rq.color.g = $urandom_range(1) ? 8'd255 : 8'd0;
          rq.color.b = $urandom_range(1) ? 8'd255 : 8'd0;
        end
      endcase
    end else begin
      rq.kind = REQ_PIXEL;
      rq.pix  = pick_written_slot();
    end
    return rq;
  endfunction

  // Greedy reduction and nearest-color lookup
  task automatic predict_mapping(input map_req_t rq, output map_result_t res);
    int   best, best_d, d;
    logic present;
    res = '0;
    if (rq.kind == REQ_LOAD) begin
      src_pal[rq.slot]     = rq.color;
      src_written[rq.slot] = 1'b1;
      res.kind = REQ_LOAD;
      if (red_count < REDUCED_COLORS) begin
        present = 1'b0;
        for (int k = 0; k < int'(red_count); k++) begin
          if (color_dist(rq.color, red_pal[k]) < int'(thr_reg)) present = 1'b1;
        end
        if (!present) begin
          red_pal[red_count] = rq.color;
          red_count          = red_count + 5'd1;
          res.added          = 1'b1;
        end
      end
      res.size = red_count;
    end else begin
      best   = 0;
      best_d = color_dist(src_pal[rq.pix], red_pal[0]);
      for (int k = 1; k < REDUCED_COLORS; k++) begin
        d = color_dist(src_pal[rq.pix], red_pal[k]);
        if (d < best_d) begin
          best_d = d;
          best   = k;
        end
      end
      res.kind  = REQ_PIXEL;
      res.size  = red_count;
      res.cidx  = 4'(best);
      res.color = red_pal[best];
      res.col   = col_cnt;
      res.row   = row_cnt;
      // raster advance, rows count down and wrap to a new frame
      if (int'(col_cnt) + 1 >= int'(width_reg) || col_cnt >= 12'd4095) begin
        col_cnt = 12'd0;
        if (row_cnt == 12'd0) row_cnt = first_row(height_reg);
        else row_cnt = row_cnt - 12'd1;
      end else begin
        col_cnt = col_cnt + 12'd1;
      end
    end
  endtask

  // Drive one request, wait for its accept, record the expected result
  task automatic send_request(input map_req_t rq, input bit known, input map_result_t golden);
    map_result_t res;
    bit          idle;
    idle = !quiet_mode && ($urandom_range(99) < IDLE_PCT);
    if (idle) begin
      in_valid_i <= 1'b0;
      while (idle) begin
        @(posedge clk_i);
        idle = ($urandom_range(99) < IDLE_PCT);
      end
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= rq.kind;
    entry_index_i <= rq.slot;
    entry_red_i   <= rq.color.r;
    entry_green_i <= rq.color.g;
    entry_blue_i  <= rq.color.b;
    pixel_index_i <= rq.pix;
    do @(posedge clk_i); while (in_stall_o);
    predict_mapping(rq, res);
    pending_results.push_back(known ? golden : res);
  endtask

  task automatic wait_for_drain(input int extra);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [17:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_WIDTH: width_reg = data[12:0];
      CFG_HEIGHT: begin
        height_reg = data[12:0];
        row_cnt    = first_row(height_reg);
      end
      default: thr_reg = data;
    endcase
  endtask

  // Idle the block, reprogram, then stream random requests
  task automatic run_phase(input logic [2:0] write_mask, input logic [12:0] w,
                           input logic [12:0] h, input logic [17:0] t,
                           input int n_items, input int load_pct, input bit calm);
    wait_for_drain(SETTLE_CYCLES);
    if (write_mask & WR_WIDTH) write_register(CFG_WIDTH, 18'(w));
    if (write_mask & WR_HEIGHT) write_register(CFG_HEIGHT, 18'(h));
    if (write_mask & WR_THRESHOLD) write_register(CFG_THRESHOLD, t);
    cfg_valid_i <= 1'b0;
    quiet_mode = calm;
    for (int i = 0; i < n_items; i++) begin
      // hold off mid-phase until every result is back
      if (i == n_items / 2) wait_for_drain(0);
      send_request(random_request(load_pct), 1'b0, '0);
    end
    quiet_mode = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result check and receiver stall
  always @(posedge clk_i) begin : result_check
    map_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("result_kind", 32'(want.kind), 32'(result_kind_o));
        compare_field("entry_added", 32'(want.added), 32'(entry_added_o));
        compare_field("reduced_size", 32'(want.size), 32'(reduced_size_o));
        compare_field("color_index", 32'(want.cidx), 32'(color_index_o));
        compare_field("out_red", 32'(want.color.r), 32'(out_red_o));
        compare_field("out_green", 32'(want.color.g), 32'(out_green_o));
        compare_field("out_blue", 32'(want.color.b), 32'(out_blue_o));
        compare_field("out_column", 32'(want.col), 32'(out_column_o));
        compare_field("out_row", 32'(want.row), 32'(out_row_o));
      end
    end
    out_stall_i <= !quiet_mode && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < SOURCE_COLORS; i++) begin
      src_pal[i]     = '0;
      src_written[i] = 1'b0;
    end
    for (int i = 0; i < REDUCED_COLORS; i++) red_pal[i] = '0;

    // Directed requests at reset register values
    add_rows();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_request(dir_rows[i].rq, dir_rows[i].known, dir_rows[i].golden);

    // width 0 acts as 1, height 0 pins row 0, nothing joins
    run_phase(WR_ALL, 13'd0, 13'd0, 18'h3FFFF, 150, 40, 1'b0);
    // very wide frame, start row saturates
    run_phase(WR_ALL, 13'd8191, 13'd8191, 18'd195076, 150, 2, 1'b0);
    // small frames wrap rows; palette grows
    run_phase(WR_ALL, 13'd3, 13'd2, 18'($urandom_range(20000, 3000)), 300, 50, 1'b0);
    // every load joins until full; row counter left alone
    run_phase(WR_WIDTH | WR_THRESHOLD, 13'd5, 13'd0, 18'd0, 250, 50, 1'b1);
    run_phase(WR_ALL, 13'd4096, 13'd4097, 18'd1600, 200, 30, 1'b0);
    run_phase(WR_ALL, 13'd1, 13'd1, 18'($urandom_range(195076)), 150, 30, 1'b0);
    // height write alone, mid-row
    run_phase(WR_HEIGHT, 13'd0, 13'd3, 18'd0, 200, 30, 1'b0);
    run_phase(WR_ALL, 13'($urandom_range(16, 1)), 13'($urandom_range(8, 1)),
              18'($urandom_range(195076)), 250, 30, 1'b0);
    run_phase(WR_ALL, 13'($urandom_range(16, 1)), 13'($urandom_range(8, 1)),
              18'($urandom_range(195076)), 250, 30, 1'b0);

    wait_for_drain(TAIL_CYCLES);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  task automatic add_row(input map_req_t rq, input bit known, input map_result_t golden);
    dir_row_t r;
    r.rq     = rq;
    r.known  = known;
    r.golden = golden;
    dir_rows.push_back(r);
  endtask

  // Threshold boundary, extremes, ties toward the lowest index
  task automatic add_rows();
    add_row(load_req(0, 0, 0, 0), 1'b1, golden_load(1, 1));
    add_row(load_req(255, 255, 255, 255), 1'b1, golden_load(1, 2));
    add_row(load_req(1, 0, 0, 39), 1'b1, golden_load(0, 2));
    add_row(load_req(2, 0, 0, 40), 1'b1, golden_load(1, 3));
    add_row(pixel_req(0), 1'b1, golden_pixel(3, 0, 0, 0, 0, 0, 767));
    add_row(pixel_req(255), 1'b1, golden_pixel(3, 1, 255, 255, 255, 1, 767));
    add_row(pixel_req(1), 1'b1, golden_pixel(3, 2, 0, 0, 40, 2, 767));
    add_row(load_req(7, 0, 0, 20), 1'b1, golden_load(0, 3));
    add_row(pixel_req(7), 1'b1, golden_pixel(3, 0, 0, 0, 0, 3, 767));
    add_row(load_req(3, 255, 0, 0), 1'b0, '0);
    add_row(load_req(4, 0, 255, 0), 1'b0, '0);
    add_row(load_req(5, 0, 0, 255), 1'b0, '0);
    add_row(load_req(6, 128, 128, 128), 1'b0, '0);
    add_row(pixel_req(3), 1'b0, '0);
    add_row(pixel_req(4), 1'b0, '0);
    add_row(pixel_req(5), 1'b0, '0);
    add_row(pixel_req(6), 1'b0, '0);
    add_row(load_req(8, 170, 85, 170), 1'b0, '0);
    add_row(load_req(9, 85, 170, 85), 1'b0, '0);
    add_row(pixel_req(8), 1'b0, '0);
    add_row(pixel_req(9), 1'b0, '0);
  endtask

endmodule
